### design/ffsra_pkg.sv
// ----------------------------------------------------------------------------
// ffsra_pkg
// Shared constants, field widths and controller/datapath command and status
// types for the first-fit slot and room allocator.
// ----------------------------------------------------------------------------
package ffsra_pkg;

  // Default sizes of the busy stores.
  localparam int MaxSlots  = 32;
  localparam int NumOwners = 64;
  localparam int NumGroups = 8;
  localparam int NumRooms  = 16;

  // Field widths of the request and result transactions.
  localparam int JobW   = 16;
  localparam int OwnerW = 6;
  localparam int GroupW = 3;
  localparam int RoomW  = 4;
  localparam int SlotW  = 6;

  // Configuration registers.
  localparam int SlotCntW = 6;
  localparam int RoomCntW = 5;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 6;

  localparam logic [CfgIdxW-1:0]  CfgSlotCount = 1'd0;
  localparam logic [CfgIdxW-1:0]  CfgRoomCount = 1'd1;

  localparam logic [SlotCntW-1:0] SlotCountRst = 6'd32;
  localparam logic [RoomCntW-1:0] RoomCountRst = 5'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the request, clear all stores if asked
    logic rd;      // read owner, group and first room words
    logic base;    // form the common free-slot word
    logic next;    // read the next room word
    logic hit;     // capture the free slots of the current room
    logic commit;  // write back and emit a placed result
    logic fail;    // emit a not-placed result
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_range;   // owner and group index real entries
    logic room_live;  // current room lies within the room count
    logic avail_any;  // current room shares a free slot
    logic out_free;   // result register can take a new result
  } dp_status_t;

endpackage

### design/ffsra_if.sv
// ----------------------------------------------------------------------------
// ffsra interfaces
// Valid/ready channels of the allocator: request, result and configuration.
// ----------------------------------------------------------------------------
interface ffsra_req_if;
  import ffsra_pkg::*;

  logic              valid;
  logic              ready;
  logic              new_schedule;
  logic [JobW-1:0]   job_id;
  logic [OwnerW-1:0] owner;
  logic [GroupW-1:0] group;

  modport source (output valid, new_schedule, job_id, owner, group, input ready);
  modport sink   (input valid, new_schedule, job_id, owner, group, output ready);
endinterface

interface ffsra_res_if;
  import ffsra_pkg::*;

  logic             valid;
  logic             ready;
  logic [JobW-1:0]  placed_job;
  logic [RoomW-1:0] room;
  logic [SlotW-1:0] slot;
  logic             ok;

  modport source (output valid, placed_job, room, slot, ok, input ready);
  modport sink   (input valid, placed_job, room, slot, ok, output ready);
endinterface

interface ffsra_cfg_if;
  import ffsra_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  reg_index;
  logic [CfgDataW-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

### design/first_fit_slot_room_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_slot_room_allocator
// Greedy first-fit allocator of a time slot and a room for each request.
// ----------------------------------------------------------------------------
// Usage. A request transaction on req_i names a job, an owner and a group, and
// may ask for all busy bitmaps to be cleared first. The block ANDs the free
// slots of that owner and that group, limited to the configured slot count,
// then tries rooms from index zero upwards and takes the first room that
// shares a free slot, choosing the lowest such slot (numbered from one). The
// slot is marked busy for the owner, the group and the room. Exactly one
// result transaction on res_o follows each request, echoing the job; ok low
// means that nothing was placed, and room and slot are then zero.
// The room scan reads one room word per cycle from the room RAM; a new
// request is accepted only once the block is idle again.
// The result waits in an output register; if the receiver stalls, the block
// finishes its next request and holds it until that register is freed.
// Reset empties every bitmap at once by clearing the valid bits, and sets the
// slot count to 32 and the room count to 16. Configuration writes on cfg_i
// are always taken and should only arrive while the block is idle.
// ----------------------------------------------------------------------------
module first_fit_slot_room_allocator #(
  parameter int MAX_SLOTS  = ffsra_pkg::MaxSlots,
  parameter int NUM_OWNERS = ffsra_pkg::NumOwners,
  parameter int NUM_GROUPS = ffsra_pkg::NumGroups,
  parameter int NUM_ROOMS  = ffsra_pkg::NumRooms
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ffsra_cfg_if.sink   cfg_i,
  ffsra_req_if.sink   req_i,
  ffsra_res_if.source res_o
);
  import ffsra_pkg::*;

  // Configuration registers.
  logic [SlotCntW-1:0] slot_count_q;
  logic [RoomCntW-1:0] room_count_q;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // The configuration port never stalls.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= SlotCountRst;
      room_count_q <= RoomCountRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.reg_index)
        CfgSlotCount: slot_count_q <= cfg_i.wdata;
        CfgRoomCount: room_count_q <= cfg_i.wdata[RoomCntW-1:0];
        default: begin
        end
      endcase
    end
  end

  // The controller sequences each request; it alone drives the request ready.
  ffsra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath holds the bitmaps and the result register.
  ffsra_dp #(
    .MAX_SLOTS  (MAX_SLOTS),
    .NUM_OWNERS (NUM_OWNERS),
    .NUM_GROUPS (NUM_GROUPS),
    .NUM_ROOMS  (NUM_ROOMS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .slot_count_i       (slot_count_q),
    .room_count_i       (room_count_q),
    .req_new_schedule_i (req_i.new_schedule),
    .req_job_id_i       (req_i.job_id),
    .req_owner_i        (req_i.owner),
    .req_group_i        (req_i.group),
    .res_ready_i        (res_o.ready),
    .res_valid_o        (res_o.valid),
    .res_placed_job_o   (res_o.placed_job),
    .res_room_o         (res_o.room),
    .res_slot_o         (res_o.slot),
    .res_ok_o           (res_o.ok)
  );

endmodule

### design/ffsra_ram.sv
// ----------------------------------------------------------------------------
// ffsra_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ffsra_ram #(
  parameter int Width = 32,
  parameter int Depth = 16,
  localparam int Aw   = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/ffsra_ctrl.sv
// ----------------------------------------------------------------------------
// ffsra_ctrl
// Sequencing state machine: accept, read, form the free set, scan the rooms,
// then commit or reject.
// ----------------------------------------------------------------------------
module ffsra_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  ffsra_pkg::dp_status_t status_i,
  output ffsra_pkg::ctrl_cmd_t  cmd_o
);
  import ffsra_pkg::*;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StRead = 6'b000010,
    StBase = 6'b000100,
    StScan = 6'b001000,
    StEnc  = 6'b010000,
    StFail = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign req_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StRead;
        end
      end
      StRead: begin
        cmd_o.rd = 1'b1;
        state_d  = StBase;
      end
      StBase: begin
        cmd_o.base = 1'b1;
        state_d    = status_i.in_range ? StScan : StFail;
      end
      StScan: begin
        if (!status_i.room_live) begin
          state_d = StFail;
        end else if (status_i.avail_any) begin
          cmd_o.hit = 1'b1;
          state_d   = StEnc;
        end else begin
          cmd_o.next = 1'b1;
        end
      end
      StEnc: begin
        if (status_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = StIdle;
        end
      end
      StFail: begin
        if (status_i.out_free) begin
          cmd_o.fail = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### design/ffsra_dp.sv
// ----------------------------------------------------------------------------
// ffsra_dp
// Datapath: request registers, the three busy stores with their valid bits,
// the room scan counter, the lowest-slot encoder and the result register.
// ----------------------------------------------------------------------------
module ffsra_dp #(
  parameter int MAX_SLOTS  = ffsra_pkg::MaxSlots,
  parameter int NUM_OWNERS = ffsra_pkg::NumOwners,
  parameter int NUM_GROUPS = ffsra_pkg::NumGroups,
  parameter int NUM_ROOMS  = ffsra_pkg::NumRooms
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ffsra_pkg::ctrl_cmd_t            cmd_i,
  output ffsra_pkg::dp_status_t           status_o,
  input  logic [ffsra_pkg::SlotCntW-1:0]  slot_count_i,
  input  logic [ffsra_pkg::RoomCntW-1:0]  room_count_i,
  input  logic                            req_new_schedule_i,
  input  logic [ffsra_pkg::JobW-1:0]      req_job_id_i,
  input  logic [ffsra_pkg::OwnerW-1:0]    req_owner_i,
  input  logic [ffsra_pkg::GroupW-1:0]    req_group_i,
  input  logic                            res_ready_i,
  output logic                            res_valid_o,
  output logic [ffsra_pkg::JobW-1:0]      res_placed_job_o,
  output logic [ffsra_pkg::RoomW-1:0]     res_room_o,
  output logic [ffsra_pkg::SlotW-1:0]     res_slot_o,
  output logic                            res_ok_o
);
  import ffsra_pkg::*;

  localparam int OwnAw    = (NUM_OWNERS > 1) ? $clog2(NUM_OWNERS) : 1;
  localparam int GrpAw    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int RoomAw   = (NUM_ROOMS > 1) ? $clog2(NUM_ROOMS) : 1;
  localparam int RoomCw   = $clog2(NUM_ROOMS + 1);
  localparam int SlotIdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  // Request registers.
  logic [JobW-1:0]   job_q;
  logic [OwnerW-1:0] owner_q;
  logic [GroupW-1:0] group_q;

  // Valid bits: an entry not yet written since the last clear reads as free.
  logic [NUM_OWNERS-1:0] own_vld_q;
  logic [NUM_GROUPS-1:0] grp_vld_q;
  logic [NUM_ROOMS-1:0]  room_vld_q;
  logic                  own_hit_q, grp_hit_q, room_hit_q;

  // Scan state.
  logic [RoomCw-1:0]    data_room_q;
  logic [RoomCw-1:0]    next_room_q;
  logic [MAX_SLOTS-1:0] base_q;
  logic [MAX_SLOTS-1:0] avail_q;

  // Result register.
  logic             res_valid_q;
  logic [JobW-1:0]  res_job_q;
  logic [RoomW-1:0] res_room_q;
  logic [SlotW-1:0] res_slot_q;
  logic             res_ok_q;

  logic                 own_ok, grp_ok, next_ok;
  logic [OwnAw-1:0]     own_addr;
  logic [GrpAw-1:0]     grp_addr;
  logic [RoomAw-1:0]    room_raddr;
  logic [RoomAw-1:0]    room_waddr;
  logic [MAX_SLOTS-1:0] own_rdata, grp_rdata, room_rdata;
  logic [MAX_SLOTS-1:0] own_old, grp_old, room_old;
  logic [MAX_SLOTS-1:0] slot_mask;
  logic [MAX_SLOTS-1:0] avail_now;
  logic [MAX_SLOTS-1:0] onehot;
  logic [SlotIdxW-1:0]  pick_idx;
  logic [SlotIdxW:0]    pick_slot;

  assign own_ok     = (32'(owner_q) < NUM_OWNERS);
  assign grp_ok     = (32'(group_q) < NUM_GROUPS);
  assign next_ok    = (32'(next_room_q) < NUM_ROOMS);
  assign own_addr   = OwnAw'(owner_q);
  assign grp_addr   = GrpAw'(group_q);
  assign room_raddr = cmd_i.rd ? '0 : next_room_q[RoomAw-1:0];
  assign room_waddr = data_room_q[RoomAw-1:0];

  assign own_old  = own_hit_q  ? own_rdata  : '0;
  assign grp_old  = grp_hit_q  ? grp_rdata  : '0;
  assign room_old = room_hit_q ? room_rdata : '0;

  always_comb begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      slot_mask[k] = (k < 32'(slot_count_i));
    end
  end

  assign avail_now = base_q & ~room_old;

  // Isolate the lowest free slot, then encode its position.
  assign onehot = avail_q & (~avail_q + 1'b1);

  always_comb begin
    pick_idx = '0;
    for (int j = 0; j < MAX_SLOTS; j++) begin
      if (onehot[j]) begin
        pick_idx = pick_idx | SlotIdxW'(j);
      end
    end
  end

  assign pick_slot = {1'b0, pick_idx} + 1'b1;

  ffsra_ram #(.Width(MAX_SLOTS), .Depth(NUM_OWNERS)) u_own_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (own_addr),
    .wdata_i (own_old | onehot),
    .re_i    (cmd_i.rd),
    .raddr_i (own_addr),
    .rdata_o (own_rdata)
  );

  ffsra_ram #(.Width(MAX_SLOTS), .Depth(NUM_GROUPS)) u_grp_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (grp_addr),
    .wdata_i (grp_old | onehot),
    .re_i    (cmd_i.rd),
    .raddr_i (grp_addr),
    .rdata_o (grp_rdata)
  );

  ffsra_ram #(.Width(MAX_SLOTS), .Depth(NUM_ROOMS)) u_room_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.commit),
    .waddr_i (room_waddr),
    .wdata_i (room_old | onehot),
    .re_i    (cmd_i.rd | cmd_i.next),
    .raddr_i (room_raddr),
    .rdata_o (room_rdata)
  );

  // Valid bits and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_vld_q   <= '0;
      grp_vld_q   <= '0;
      room_vld_q  <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && req_new_schedule_i) begin
        own_vld_q  <= '0;
        grp_vld_q  <= '0;
        room_vld_q <= '0;
      end else if (cmd_i.commit) begin
        own_vld_q[own_addr]    <= 1'b1;
        grp_vld_q[grp_addr]    <= 1'b1;
        room_vld_q[room_waddr] <= 1'b1;
      end
      if (cmd_i.commit || cmd_i.fail) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      job_q   <= req_job_id_i;
      owner_q <= req_owner_i;
      group_q <= req_group_i;
    end
    if (cmd_i.rd) begin
      own_hit_q   <= own_ok && own_vld_q[own_addr];
      grp_hit_q   <= grp_ok && grp_vld_q[grp_addr];
      room_hit_q  <= room_vld_q[0];
      data_room_q <= '0;
      next_room_q <= RoomCw'(1);
    end else if (cmd_i.next) begin
      room_hit_q  <= next_ok && room_vld_q[room_raddr];
      data_room_q <= next_room_q;
      next_room_q <= next_room_q + 1'b1;
    end
    if (cmd_i.base) begin
      base_q <= ~(own_old | grp_old) & slot_mask;
    end
    if (cmd_i.hit) begin
      avail_q <= avail_now;
    end
    if (cmd_i.commit) begin
      res_job_q  <= job_q;
      res_room_q <= RoomW'(data_room_q);
      res_slot_q <= SlotW'(pick_slot);
      res_ok_q   <= 1'b1;
    end else if (cmd_i.fail) begin
      res_job_q  <= job_q;
      res_room_q <= '0;
      res_slot_q <= '0;
      res_ok_q   <= 1'b0;
    end
  end

  assign status_o.in_range  = own_ok && grp_ok;
  assign status_o.room_live = (32'(data_room_q) < 32'(room_count_i)) &&
                              (32'(data_room_q) < NUM_ROOMS);
  assign status_o.avail_any = |avail_now;
  assign status_o.out_free  = !res_valid_q || res_ready_i;

  assign res_valid_o      = res_valid_q;
  assign res_placed_job_o = res_job_q;
  assign res_room_o       = res_room_q;
  assign res_slot_o       = res_slot_q;
  assign res_ok_o         = res_ok_q;

endmodule

### dv/first_fit_slot_room_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_slot_room_allocator_test
// Self-checking testbench of the first-fit slot and room allocator. Requests
// go in on the request channel and each placement is compared with a local
// model of the owner, group and room busy bitmaps. The run starts with short
// directed tests of the counts and their extremes and then moves to random
// request sequences under several idling patterns and a long receiver stall.
// ----------------------------------------------------------------------------
module first_fit_slot_room_allocator_test;
  import ffsra_pkg::*;

  localparam int SlotBitW = $clog2(MaxSlots);

  typedef struct packed {
    logic              new_schedule;
    logic [JobW-1:0]   job_id;
    logic [OwnerW-1:0] owner;
    logic [GroupW-1:0] group;
  } request_t;

  typedef struct packed {
    logic [JobW-1:0]  placed_job;
    logic [RoomW-1:0] room;
    logic [SlotW-1:0] slot;
    logic             ok;
  } placement_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ffsra_cfg_if cfg_bus ();
  ffsra_req_if req_bus ();
  ffsra_res_if res_bus ();

  first_fit_slot_room_allocator DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .req_i  (req_bus),
    .res_o  (res_bus)
  );

  always #1 clk_i = ~clk_i;

  // Local copy of the allocator state. Bit k of a bitmap set means that slot
  // k + 1 is already taken by that owner, group or room.
  logic [MaxSlots-1:0] owner_busy [NumOwners];
  logic [MaxSlots-1:0] group_busy [NumGroups];
  logic [MaxSlots-1:0] room_busy  [NumRooms];
  int unsigned         slot_limit;
  int unsigned         room_limit;

  // Placements still owed by the block, oldest first.
  placement_t expected_placements [$];
  int         mismatch_count = 0;

  // Idling controls. The sender leaves a cycle idle, and the receiver stalls
  // a cycle, with these chances out of a hundred.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // A long receiver hold-off is requested by bumping hold_seq; the receiver
  // process then counts hold_len cycles with ready held low.
  int hold_len = 0;
  int hold_seq = 0;

  function automatic void clear_bitmaps();
    foreach (owner_busy[i]) owner_busy[i] = '0;
    foreach (group_busy[i]) group_busy[i] = '0;
    foreach (room_busy[i])  room_busy[i]  = '0;
  endfunction

  // Works out the placement of one accepted request and updates the busy
  // bitmaps exactly as the block should.
  function automatic placement_t place_request(input request_t rq);
    placement_t          pl;
    logic [MaxSlots-1:0] usable;
    logic [MaxSlots-1:0] avail;
    int unsigned         n_slots;
    int unsigned         n_rooms;
    int                  r;
    int                  k;
    int                  lowest;
    pl            = '0;
    pl.placed_job = rq.job_id;
    // A clear takes effect whether or not the request is placed.
    if (rq.new_schedule) clear_bitmaps();
    // Counts beyond the store sizes saturate.
    n_slots = (slot_limit > MaxSlots) ? MaxSlots : slot_limit;
    n_rooms = (room_limit > NumRooms) ? NumRooms : room_limit;
    if (32'(rq.owner) < NumOwners && 32'(rq.group) < NumGroups) begin
      usable = ~(owner_busy[rq.owner] | group_busy[rq.group]);
      for (k = 0; k < MaxSlots; k++) begin
        if (k >= n_slots) usable[SlotBitW'(k)] = 1'b0;
      end
      for (r = 0; r < n_rooms && !pl.ok; r++) begin
        avail = usable & ~room_busy[RoomW'(r)];
        if (avail != '0) begin
          lowest = 0;
          for (k = MaxSlots - 1; k >= 0; k--) begin
            if (avail[SlotBitW'(k)]) lowest = k;
          end
          pl.ok   = 1'b1;
          pl.room = RoomW'(r);
          pl.slot = SlotW'(lowest + 1);
          owner_busy[rq.owner][SlotBitW'(lowest)] = 1'b1;
          group_busy[rq.group][SlotBitW'(lowest)] = 1'b1;
          room_busy[RoomW'(r)][SlotBitW'(lowest)] = 1'b1;
        end
      end
    end
    return pl;
  endfunction

  function automatic request_t make_request(input logic ns, input logic [JobW-1:0] job,
                                            input logic [OwnerW-1:0] own,
                                            input logic [GroupW-1:0] grp);
    request_t rq;
    rq.new_schedule = ns;
    rq.job_id       = job;
    rq.owner        = own;
    rq.group        = grp;
    return rq;
  endfunction

  // Offers one request, starting at a falling edge, and records its expected
  // placement once the transaction has been accepted. Valid is left high on
  // return so that a following request can go out back to back.
  task automatic send_request(input request_t rq);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid        = 1'b1;
    req_bus.new_schedule = rq.new_schedule;
    req_bus.job_id       = rq.job_id;
    req_bus.owner        = rq.owner;
    req_bus.group        = rq.group;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
    expected_placements.insert(expected_placements.size(), place_request(rq));
    @(negedge clk_i);
  endtask

  // Writes one configuration register and mirrors it in the local model.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_bus.valid     = 1'b1;
    cfg_bus.reg_index = idx;
    cfg_bus.wdata     = data;
    @(posedge clk_i);
    while (!cfg_bus.ready) @(posedge clk_i);
    case (idx)
      CfgSlotCount: slot_limit = 32'(data);
      CfgRoomCount: room_limit = 32'(data[RoomCntW-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
    @(negedge clk_i);
  endtask

  // Stops offering requests and waits until every placement has come back,
  // then lets the block settle before returning.
  task automatic wait_idle();
    req_bus.valid = 1'b0;
    while (expected_placements.size() != 0) @(negedge clk_i);
    repeat (25) @(negedge clk_i);
  endtask

  task automatic report_mismatch(input string what, input placement_t want,
                                 input placement_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: job exp %h got %h, room exp %0d got %0d, slot exp %0d got %0d, ok exp %b got %b",
               what, want.placed_job, got.placed_job, want.room, got.room,
               want.slot, got.slot, want.ok, got.ok);
    end
  endtask

  // Every result transaction is checked against the oldest expectation.
  always @(posedge clk_i) begin : check_placements
    placement_t got;
    placement_t want;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got.placed_job = res_bus.placed_job;
      got.room       = res_bus.room;
      got.slot       = res_bus.slot;
      got.ok         = res_bus.ok;
      if (expected_placements.size() == 0) begin
        report_mismatch("unexpected result", got, got);
      end else begin
        want = expected_placements.pop_front();
        if (got.placed_job !== want.placed_job || got.room !== want.room ||
            got.slot !== want.slot || got.ok !== want.ok) begin
          report_mismatch("placement mismatch", want, got);
        end
      end
    end
  end

  // Result receiver. Ready changes only at the falling edge; a requested
  // hold-off overrides the random stalls until its cycle count runs out.
  initial begin : result_receiver
    int hold_seen;
    int hold_left;
    hold_seen     = 0;
    hold_left     = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        res_bus.ready = 1'b0;
        hold_left--;
      end else begin
        res_bus.ready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Random requests, mostly as runs that start a fresh schedule and then
  // keep hitting a small pool of owners and groups, so that bitmaps fill up,
  // high slots are reached and requests start to fail. The rest is noise
  // over the full field ranges.
  task automatic run_random(input int count);
    request_t rq;
    int       sent;
    int       seq_len;
    int       own_lo;
    int       own_span;
    int       grp_lo;
    int       grp_span;
    int       i;
    sent = 0;
    while (sent < count) begin
      seq_len  = $urandom_range(8, 40);
      own_lo   = $urandom_range(0, NumOwners - 4);
      own_span = $urandom_range(0, 3);
      grp_lo   = $urandom_range(0, NumGroups - 2);
      grp_span = $urandom_range(0, 1);
      for (i = 0; i < seq_len && sent < count; i++) begin
        rq.job_id = JobW'($urandom);
        if ($urandom_range(0, 99) < 85) begin
          rq.new_schedule = (i == 0) && ($urandom_range(0, 4) != 0);
          rq.owner        = OwnerW'(own_lo + $urandom_range(0, own_span));
          rq.group        = GroupW'(grp_lo + $urandom_range(0, grp_span));
        end else begin
          rq.new_schedule = ($urandom_range(0, 9) == 0);
          rq.owner        = OwnerW'($urandom);
          rq.group        = GroupW'($urandom);
        end
        send_request(rq);
        sent++;
      end
    end
  endtask

  // With the reset counts: field extremes and the basic first-fit choices.
  // A second owner and group find slot 1 of room 0 taken and get slot 2 there,
  // and sharing an owner or a group must push the choice to a later slot.
  task automatic test_default_placement();
    send_request(make_request(1'b1, 16'h0000, 6'd0,  3'd0));
    send_request(make_request(1'b0, 16'hFFFF, 6'd63, 3'd7));
    send_request(make_request(1'b0, 16'h1234, 6'd0,  3'd7));
    send_request(make_request(1'b0, 16'h5AA5, 6'd63, 3'd0));
    send_request(make_request(1'b0, 16'hA55A, 6'd21, 3'd2));
    send_request(make_request(1'b0, 16'h8001, 6'd42, 3'd5));
    wait_idle();
  endtask

  // One slot and one room: the second distinct request finds no room. Then
  // a second room is opened and the same request fits there.
  task automatic test_tight_counts();
    write_reg(CfgSlotCount, 6'd1);
    write_reg(CfgRoomCount, 6'd1);
    send_request(make_request(1'b1, 16'h0101, 6'd1, 3'd1));
    send_request(make_request(1'b0, 16'h0202, 6'd2, 3'd2));
    wait_idle();
    write_reg(CfgRoomCount, 6'd2);
    send_request(make_request(1'b0, 16'h0303, 6'd2, 3'd2));
    wait_idle();
  endtask

  // A zero slot count fails every request, yet a clear asked for in the same
  // request must still happen: the request after it finds room 0 free again.
  // A zero room count fails as well.
  task automatic test_zero_counts();
    write_reg(CfgSlotCount, 6'd0);
    send_request(make_request(1'b1, 16'h0404, 6'd3, 3'd3));
    wait_idle();
    write_reg(CfgSlotCount, 6'd1);
    send_request(make_request(1'b0, 16'h0505, 6'd4, 3'd4));
    wait_idle();
    write_reg(CfgRoomCount, 6'd0);
    send_request(make_request(1'b0, 16'h0606, 6'd5, 3'd5));
    wait_idle();
  endtask

  // Counts written above the store sizes saturate. The room count is written
  // with all data bits set, the spare top bit included.
  task automatic test_count_saturation();
    write_reg(CfgSlotCount, 6'd63);
    write_reg(CfgRoomCount, 6'd63);
    send_request(make_request(1'b1, 16'h0707, 6'd9,  3'd4));
    send_request(make_request(1'b0, 16'h0808, 6'd9,  3'd4));
    send_request(make_request(1'b0, 16'h0909, 6'd10, 3'd5));
    send_request(make_request(1'b0, 16'h0A0A, 6'd10, 3'd4));
    wait_idle();
  endtask

  // Random traffic in four phases, each with its own counts and idling.
  task automatic test_random_phases();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CfgSlotCount, 6'd32);
    write_reg(CfgRoomCount, 6'd16);
    run_random(140);
    wait_idle();

    send_idle_pct  = 75;
    recv_stall_pct = 0;
    write_reg(CfgSlotCount, 6'd63);
    write_reg(CfgRoomCount, 6'd63);
    run_random(140);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 75;
    write_reg(CfgSlotCount, CfgDataW'($urandom_range(1, MaxSlots)));
    write_reg(CfgRoomCount, CfgDataW'($urandom_range(1, NumRooms)));
    run_random(140);
    wait_idle();

    // Few slots and rooms make failures common.
    send_idle_pct  = 28;
    recv_stall_pct = 28;
    write_reg(CfgSlotCount, 6'd6);
    write_reg(CfgRoomCount, 6'd3);
    run_random(140);
    wait_idle();
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the output register fills and the block has to stall its input.
  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(CfgSlotCount, 6'd32);
    write_reg(CfgRoomCount, 6'd16);
    @(posedge clk_i);
    hold_len = 300;
    hold_seq++;
    @(negedge clk_i);
    run_random(50);
    wait_idle();
  endtask

  initial begin
    rst_ni               = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.reg_index    = CfgSlotCount;
    cfg_bus.wdata        = '0;
    req_bus.valid        = 1'b0;
    req_bus.new_schedule = 1'b0;
    req_bus.job_id       = '0;
    req_bus.owner        = '0;
    req_bus.group        = '0;
    clear_bitmaps();
    slot_limit = 32'(SlotCountRst);
    room_limit = 32'(RoomCountRst);
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (4) @(negedge clk_i);

    test_default_placement();
    test_tight_counts();
    test_zero_counts();
    test_count_saturation();
    test_random_phases();
    test_output_backpressure();

    // wait_idle has already drained every placement; anything still owed here
    // counts as a failure.
    wait_idle();
    if (mismatch_count == 0 && expected_placements.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run could take.
  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
